>>> src/assert_macros.svh
// Assertion macros used by the checker file of the maze step block.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, disabled during reset.
`define ASSERT_SAME(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle, disabled during reset.
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mbt_pkg.sv
// Shared types, constants and helper functions for the maze step block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mbt_pkg;

   localparam int GRID_SIDE  = 10;
   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

   localparam int COORD_W   = 4;
   localparam int ROW_IDX_W = $clog2(GRID_SIDE);
   localparam int CNT_W     = $clog2(CELL_COUNT + 1);
   localparam int ADDR_W    = $clog2(CELL_COUNT);
   localparam int DIR_W     = 2;
   localparam int CORNER_W  = 2;
   localparam int EVENT_W   = 3;
   localparam int VISITED_W = 7;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_BITS    = EVENT_W + 2 * COORD_W + DIR_W + VISITED_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [COORD_W-1:0] LAST_IDX   = COORD_W'(GRID_SIDE - 1);
   localparam logic [CNT_W-1:0]   CELLS_ALL  = CNT_W'(CELL_COUNT);

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   localparam logic [CORNER_W-1:0] CORNER_TOP_LEFT    = 2'd0;
   localparam logic [CORNER_W-1:0] CORNER_BOTTOM_LEFT = 2'd1;
   localparam logic [CORNER_W-1:0] CORNER_TOP_RIGHT   = 2'd2;

   localparam logic [EVENT_W-1:0] EV_CARVED  = 3'd0;
   localparam logic [EVENT_W-1:0] EV_NOMOVE  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_BACK    = 3'd2;
   localparam logic [EVENT_W-1:0] EV_DONE    = 3'd3;
   localparam logic [EVENT_W-1:0] EV_RESTART = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } cell_type;

   typedef struct packed {
      logic     ok;
      cell_type pos;
   } nbr_type;

   typedef struct packed {
      logic     restart;
      logic     mark;
      cell_type pos;
   } map_ctl_type;

   typedef struct packed {
      logic     clear;
      logic     push;
      logic     pop;
      cell_type pos;
   } stack_ctl_type;

   function automatic nbr_type neighbor(logic [DIR_W-1:0] dir, cell_type cur);
      nbr_type nb;
      nb.ok  = 1'b0;
      nb.pos = cur;
      case (dir)
         DIR_UP: begin
            nb.ok = (cur.row != '0);
            if (nb.ok) nb.pos.row = cur.row - COORD_W'(1);
         end
         DIR_DOWN: begin
            nb.ok = (cur.row < LAST_IDX);
            if (nb.ok) nb.pos.row = cur.row + COORD_W'(1);
         end
         DIR_LEFT: begin
            nb.ok = (cur.col != '0);
            if (nb.ok) nb.pos.col = cur.col - COORD_W'(1);
         end
         DIR_RIGHT: begin
            nb.ok = (cur.col < LAST_IDX);
            if (nb.ok) nb.pos.col = cur.col + COORD_W'(1);
         end
         default: begin
            nb.ok = 1'b0;
         end
      endcase
      return nb;
   endfunction

   function automatic cell_type start_cell(logic [CORNER_W-1:0] corner);
      cell_type c;
      c.row = '0;
      c.col = '0;
      case (corner)
         CORNER_BOTTOM_LEFT: c.row = LAST_IDX;
         CORNER_TOP_RIGHT:   c.col = LAST_IDX;
         default:            c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

>>> src/maze_backtracker_step.sv
// Top level of the maze step block: input register, step decision and result register.
// Instantiates mbt_visit_map and mbt_path_stack; uses mbt_pkg.
//
// Each accepted transfer is one step of a randomized depth-first maze walk over a
// 10 by 10 grid and yields exactly one result transfer. A transfer is held in the
// input register, where the step is decided against the visited map and the path
// stack, and then waits in the result register; the block sustains one transfer per
// cycle while the result side does not stall. The path stack memory needs no clearing
// pass, so the block takes transfers right after reset.
`default_nettype none

module maze_backtracker_step (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [mbt_pkg::CORNER_W-1:0]         csr_wr_data,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [mbt_pkg::REQ_TDATA_W-1:0]      req_tdata,   // random_dir
   input  wire                                  req_tuser,   // restart
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // event_res, cell_row, cell_col, carved_dir, cells_visited
   output logic [mbt_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   logic [mbt_pkg::CORNER_W-1:0]  corner_ff;
   logic                          in_valid_ff;
   logic [mbt_pkg::DIR_W-1:0]     in_dir_ff;
   logic                          in_restart_ff;
   mbt_pkg::cell_type             cur_ff;
   mbt_pkg::cell_type             cur_in;
   logic [mbt_pkg::CNT_W-1:0]     count_ff;
   logic [mbt_pkg::CNT_W-1:0]     count_in;
   logic                          rsp_valid_ff;
   logic [mbt_pkg::EVENT_W-1:0]   rsp_event_ff;
   logic [mbt_pkg::EVENT_W-1:0]   rsp_event_in;
   logic [mbt_pkg::DIR_W-1:0]     rsp_carved_ff;
   logic [mbt_pkg::DIR_W-1:0]     rsp_carved_in;
   mbt_pkg::cell_type             rsp_cell_ff;
   logic [mbt_pkg::CNT_W-1:0]     rsp_count_ff;

   logic                          fire;
   logic [3:0]                    free_way;
   logic [mbt_pkg::CNT_W-1:0]     depth;
   mbt_pkg::cell_type             top_cell;
   mbt_pkg::nbr_type              nb;
   mbt_pkg::map_ctl_type          map_ctl;
   mbt_pkg::stack_ctl_type        stack_ctl;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   mbt_visit_map u_map (
      .clock    (clock),
      .reset    (reset),
      .ctl      (map_ctl),
      .cur      (cur_ff),
      .free_way (free_way)
   );

   mbt_path_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .ctl      (stack_ctl),
      .depth    (depth),
      .top_cell (top_cell)
   );

   always_comb begin
      nb            = mbt_pkg::neighbor(in_dir_ff, cur_ff);
      cur_in        = cur_ff;
      count_in      = count_ff;
      rsp_event_in  = mbt_pkg::EV_NOMOVE;
      rsp_carved_in = '0;
      map_ctl       = '0;
      stack_ctl     = '0;
      stack_ctl.pos = cur_ff;
      if (in_restart_ff) begin
         cur_in           = mbt_pkg::start_cell(corner_ff);
         count_in         = mbt_pkg::CNT_W'(1);
         rsp_event_in     = mbt_pkg::EV_RESTART;
         map_ctl.restart  = fire;
         map_ctl.pos      = cur_in;
         stack_ctl.clear  = fire;
      end else if (count_ff >= mbt_pkg::CELLS_ALL) begin
         rsp_event_in = mbt_pkg::EV_DONE;
      end else if (free_way != '0) begin
         if (free_way[in_dir_ff] && depth < mbt_pkg::CELLS_ALL) begin
            cur_in         = nb.pos;
            count_in       = count_ff + mbt_pkg::CNT_W'(1);
            rsp_event_in   = mbt_pkg::EV_CARVED;
            rsp_carved_in  = in_dir_ff;
            map_ctl.mark   = fire;
            map_ctl.pos    = nb.pos;
            stack_ctl.push = fire;
         end
      end else if (depth != '0) begin
         cur_in.row    = (top_cell.row > mbt_pkg::LAST_IDX) ? mbt_pkg::LAST_IDX : top_cell.row;
         cur_in.col    = (top_cell.col > mbt_pkg::LAST_IDX) ? mbt_pkg::LAST_IDX : top_cell.col;
         rsp_event_in  = mbt_pkg::EV_BACK;
         stack_ctl.pop = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= mbt_pkg::CORNER_TOP_LEFT;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= mbt_pkg::start_cell(mbt_pkg::CORNER_TOP_LEFT);
         count_ff     <= mbt_pkg::CNT_W'(1);
      end else begin
         if (csr_wr_en) begin
            corner_ff <= csr_wr_data;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            cur_ff       <= cur_in;
            count_ff     <= count_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_dir_ff     <= req_tdata[mbt_pkg::DIR_W-1:0];
         in_restart_ff <= req_tuser;
      end
      if (fire) begin
         rsp_event_ff  <= rsp_event_in;
         rsp_carved_ff <= rsp_carved_in;
         rsp_cell_ff   <= cur_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (mbt_pkg::RSP_TDATA_W - mbt_pkg::RSP_BITS)'(0),
      mbt_pkg::VISITED_W'(rsp_count_ff),
      rsp_carved_ff,
      rsp_cell_ff.col,
      rsp_cell_ff.row,
      rsp_event_ff
   };

endmodule

`default_nettype wire

>>> src/mbt_visit_map.sv
// Visited-cell map held in flip-flops, one bit per grid cell.
// Reports which neighbors of the current cell are free; uses mbt_pkg.
`default_nettype none

module mbt_visit_map (
   input  wire                    clock,
   input  wire                    reset,
   input  mbt_pkg::map_ctl_type   ctl,
   input  mbt_pkg::cell_type      cur,
   output logic [3:0]             free_way
);

   logic [mbt_pkg::GRID_SIDE-1:0][mbt_pkg::GRID_SIDE-1:0] vis_ff;
   logic [mbt_pkg::GRID_SIDE-1:0][mbt_pkg::GRID_SIDE-1:0] vis_in;

   always_comb begin
      mbt_pkg::nbr_type nb;
      nb = '0;
      for (int d = 0; d < 4; d++) begin
         nb = mbt_pkg::neighbor(mbt_pkg::DIR_W'(d), cur);
         free_way[d] = nb.ok &&
            !vis_ff[nb.pos.row[mbt_pkg::ROW_IDX_W-1:0]][nb.pos.col[mbt_pkg::ROW_IDX_W-1:0]];
      end
   end

   always_comb begin
      vis_in = vis_ff;
      if (ctl.restart) begin
         vis_in = '0;
         vis_in[ctl.pos.row[mbt_pkg::ROW_IDX_W-1:0]][ctl.pos.col[mbt_pkg::ROW_IDX_W-1:0]]
            = 1'b1;
      end else if (ctl.mark) begin
         vis_in[ctl.pos.row[mbt_pkg::ROW_IDX_W-1:0]][ctl.pos.col[mbt_pkg::ROW_IDX_W-1:0]]
            = 1'b1;
      end
   end

   // Reset leaves only the top-left cell marked.
   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff <= mbt_pkg::CELL_COUNT'(1);
      end else begin
         vis_ff <= vis_in;
      end
   end

endmodule

`default_nettype wire

>>> src/mbt_path_stack.sv
// Path stack of the walk: a memory with the top entry held in a register
// and the entry below it prefetched whenever two or more entries are held. Uses mbt_pkg.
`default_nettype none

module mbt_path_stack (
   input  wire                        clock,
   input  wire                        reset,
   input  mbt_pkg::stack_ctl_type     ctl,
   output logic [mbt_pkg::CNT_W-1:0]  depth,
   output mbt_pkg::cell_type          top_cell
);

   mbt_pkg::cell_type mem [mbt_pkg::CELL_COUNT];

   logic [mbt_pkg::CNT_W-1:0]  depth_ff;
   logic [mbt_pkg::CNT_W-1:0]  depth_in;
   logic [mbt_pkg::CNT_W-1:0]  below_idx;
   mbt_pkg::cell_type          tos_ff;
   mbt_pkg::cell_type          tos_in;
   mbt_pkg::cell_type          below_ff;

   always_comb begin
      depth_in = depth_ff;
      tos_in   = tos_ff;
      if (ctl.clear) begin
         depth_in = '0;
      end else if (ctl.push) begin
         depth_in = depth_ff + mbt_pkg::CNT_W'(1);
         tos_in   = ctl.pos;
      end else if (ctl.pop) begin
         depth_in = depth_ff - mbt_pkg::CNT_W'(1);
         tos_in   = below_ff;
      end
      below_idx = depth_in - mbt_pkg::CNT_W'(2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      if (ctl.push && !ctl.clear) begin
         mem[depth_ff[mbt_pkg::ADDR_W-1:0]] <= ctl.pos;
      end
      if (depth_in >= mbt_pkg::CNT_W'(2)) begin
         below_ff <= mem[below_idx[mbt_pkg::ADDR_W-1:0]];
      end
   end

   assign depth    = depth_ff;
   assign top_cell = tos_ff;

endmodule

`default_nettype wire

>>> src/mbt_checker.sv
// Port-level checker for the maze step block, bound to its top level.
// Uses assert_macros.svh and mbt_pkg.
`default_nettype none

`include "assert_macros.svh"

module mbt_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [mbt_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);

   logic [mbt_pkg::EVENT_W-1:0]   ev;
   logic [mbt_pkg::COORD_W-1:0]   row;
   logic [mbt_pkg::COORD_W-1:0]   col;
   logic [mbt_pkg::VISITED_W-1:0] visited;

   assign ev      = rsp_tdata[2:0];
   assign row     = rsp_tdata[6:3];
   assign col     = rsp_tdata[10:7];
   assign visited = rsp_tdata[19:13];

   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "Result transfer was withdrawn before it was taken.")

   `ASSERT_SAME(a_cell_in_grid, rsp_tvalid,
      row <= mbt_pkg::LAST_IDX && col <= mbt_pkg::LAST_IDX,
      "Reported cell lies outside the grid.")

   `ASSERT_SAME(a_restart_count, rsp_tvalid && ev == mbt_pkg::EV_RESTART,
      visited == mbt_pkg::VISITED_W'(1),
      "Restart result does not report a single visited cell.")

   `ASSERT_SAME(a_done_count, rsp_tvalid && ev == mbt_pkg::EV_DONE,
      visited == mbt_pkg::VISITED_W'(mbt_pkg::CELL_COUNT),
      "Finished result reported before every cell was visited.")

endmodule

bind maze_backtracker_step mbt_checker u_mbt_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for maze_backtracker_step: directed and random maze walks checked
// against a step predictor. Depends on mbt_pkg and the maze_backtracker_step RTL only.

module testbench;

   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 750;
   localparam int QUIET_AFTER  = 650;
   localparam logic [mbt_pkg::CORNER_W-1:0] CORNER_SPARE = 2'd3;

   typedef struct packed {
      logic [mbt_pkg::VISITED_W-1:0] visited;
      logic [mbt_pkg::DIR_W-1:0]     carved;
      logic [mbt_pkg::COORD_W-1:0]   col;
      logic [mbt_pkg::COORD_W-1:0]   row;
      logic [mbt_pkg::EVENT_W-1:0]   event_code;
   } step_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [mbt_pkg::CORNER_W-1:0]    csr_wr_data = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mbt_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mbt_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   logic [mbt_pkg::CORNER_W-1:0] corner_reg;
   logic                         cell_seen [mbt_pkg::CELL_COUNT];
   mbt_pkg::cell_type            trail [mbt_pkg::CELL_COUNT];
   int unsigned                  trail_depth;
   mbt_pkg::cell_type            here;
   int unsigned                  visits;
   step_result_type              pending_steps [$];

   int error_count = 0;
   int stall_cycles = 0;
   int sender_idle_odds = 5;
   int random_sent = 0;
   bit quiet = 1'b0;

   maze_backtracker_step dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #10 clock = ~clock;

   function automatic int cell_index(mbt_pkg::cell_type c);
      return int'(c.row) * mbt_pkg::GRID_SIDE + int'(c.col);
   endfunction

   function automatic bit try_move(logic [mbt_pkg::DIR_W-1:0] dir,
                                   output mbt_pkg::cell_type target);
      target = here;
      case (dir)
         mbt_pkg::DIR_UP: begin
            if (here.row == 0) return 1'b0;
            target.row = here.row - 4'd1;
         end
         mbt_pkg::DIR_DOWN: begin
            if (here.row == mbt_pkg::LAST_IDX) return 1'b0;
            target.row = here.row + 4'd1;
         end
         mbt_pkg::DIR_LEFT: begin
            if (here.col == 0) return 1'b0;
            target.col = here.col - 4'd1;
         end
         default: begin
            if (here.col == mbt_pkg::LAST_IDX) return 1'b0;
            target.col = here.col + 4'd1;
         end
      endcase
      return 1'b1;
   endfunction

   function automatic bit open_way(logic [mbt_pkg::DIR_W-1:0] dir);
      mbt_pkg::cell_type target;
      if (!try_move(dir, target)) return 1'b0;
      return !cell_seen[cell_index(target)];
   endfunction

   function automatic void restart_walk();
      foreach (cell_seen[i]) cell_seen[i] = 1'b0;
      trail_depth = 0;
      here = '0;
      if (corner_reg == mbt_pkg::CORNER_BOTTOM_LEFT) here.row = mbt_pkg::LAST_IDX;
      else if (corner_reg == mbt_pkg::CORNER_TOP_RIGHT) here.col = mbt_pkg::LAST_IDX;
      cell_seen[cell_index(here)] = 1'b1;
      visits = 1;
   endfunction

   function automatic step_result_type walk_step(logic [mbt_pkg::DIR_W-1:0] dir,
                                                 logic restart);
      step_result_type   res;
      mbt_pkg::cell_type target;
      res.event_code = mbt_pkg::EV_NOMOVE;
      res.carved = '0;
      if (restart) begin
         restart_walk();
         res.event_code = mbt_pkg::EV_RESTART;
      end else if (visits >= mbt_pkg::CELL_COUNT) begin
         res.event_code = mbt_pkg::EV_DONE;
      end else if (open_way(mbt_pkg::DIR_UP) || open_way(mbt_pkg::DIR_DOWN)
                   || open_way(mbt_pkg::DIR_LEFT) || open_way(mbt_pkg::DIR_RIGHT)) begin
         if (open_way(dir) && trail_depth < mbt_pkg::CELL_COUNT) begin
            void'(try_move(dir, target));
            trail[trail_depth] = here;
            trail_depth++;
            here = target;
            cell_seen[cell_index(here)] = 1'b1;
            visits++;
            res.carved = dir;
            res.event_code = mbt_pkg::EV_CARVED;
         end
      end else if (trail_depth > 0) begin
         trail_depth--;
         here = trail[trail_depth];
         res.event_code = mbt_pkg::EV_BACK;
      end
      res.row = here.row;
      res.col = here.col;
      res.visited = mbt_pkg::VISITED_W'(visits);
      return res;
   endfunction

   function automatic logic [mbt_pkg::DIR_W-1:0] pick_dir();
      logic [mbt_pkg::DIR_W-1:0] d;
      d = mbt_pkg::DIR_W'($urandom);
      if ($urandom_range(0, 9) < 8) begin
         for (int k = 0; k < 4; k++) begin
            if (open_way(d)) return d;
            d = d + 2'd1;
         end
      end
      return d;
   endfunction

   task automatic send_step(input logic [mbt_pkg::DIR_W-1:0] dir, input logic restart);
      if (!quiet && sender_idle_odds > 0 && $urandom_range(0, sender_idle_odds - 1) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= mbt_pkg::REQ_TDATA_W'(dir);
      req_tuser <= restart;
      do @(posedge clock); while (!req_tready);
      pending_steps.push_back(walk_step(dir, restart));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_steps.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_corner(input logic [mbt_pkg::CORNER_W-1:0] corner);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= corner;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      corner_reg = corner;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic test_border_and_carve();
      logic [mbt_pkg::DIR_W-1:0] dirs [11] = '{
         mbt_pkg::DIR_UP, mbt_pkg::DIR_LEFT, mbt_pkg::DIR_DOWN, mbt_pkg::DIR_UP,
         mbt_pkg::DIR_RIGHT, mbt_pkg::DIR_RIGHT, mbt_pkg::DIR_UP, mbt_pkg::DIR_LEFT,
         mbt_pkg::DIR_RIGHT, mbt_pkg::DIR_DOWN, mbt_pkg::DIR_RIGHT};
      foreach (dirs[i]) send_step(dirs[i], 1'b0);
   endtask

   task automatic test_corner_restarts();
      write_corner(mbt_pkg::CORNER_BOTTOM_LEFT);
      send_step(mbt_pkg::DIR_RIGHT, 1'b0);
      send_step(mbt_pkg::DIR_UP, 1'b1);
      send_step(mbt_pkg::DIR_DOWN, 1'b0);
      send_step(mbt_pkg::DIR_LEFT, 1'b0);
      send_step(mbt_pkg::DIR_UP, 1'b0);
      write_corner(mbt_pkg::CORNER_TOP_RIGHT);
      send_step(mbt_pkg::DIR_RIGHT, 1'b1);
      send_step(mbt_pkg::DIR_UP, 1'b0);
      send_step(mbt_pkg::DIR_RIGHT, 1'b0);
      send_step(mbt_pkg::DIR_LEFT, 1'b0);
      write_corner(CORNER_SPARE);
      send_step(mbt_pkg::DIR_DOWN, 1'b1);
      send_step(mbt_pkg::DIR_LEFT, 1'b0);
   endtask

   task automatic test_random_walks();
      logic [mbt_pkg::CORNER_W-1:0] corners [4] = '{
         mbt_pkg::CORNER_TOP_RIGHT, mbt_pkg::CORNER_BOTTOM_LEFT, CORNER_SPARE,
         mbt_pkg::CORNER_TOP_LEFT};
      int phase = 0;
      int phase_items;
      int done_items;
      while (random_sent < RANDOM_ITEMS) begin
         write_corner(corners[phase % 4]);
         sender_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : 6;
         send_step(mbt_pkg::DIR_W'($urandom), 1'b1);
         random_sent++;
         phase_items = 0;
         done_items = 0;
         while (random_sent < RANDOM_ITEMS && done_items < 6 && phase_items < 400) begin
            if (random_sent >= QUIET_AFTER) quiet = 1'b1;
            if ($urandom_range(0, 199) == 0) send_step(mbt_pkg::DIR_W'($urandom), 1'b1);
            else send_step(pick_dir(), 1'b0);
            if (visits >= mbt_pkg::CELL_COUNT) done_items++;
            if ($urandom_range(0, 149) == 0) drain_results();
            phase_items++;
            random_sent++;
         end
         phase++;
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      step_result_type got;
      step_result_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got = step_result_type'(rsp_tdata[mbt_pkg::RSP_BITS-1:0]);
            if (pending_steps.size() == 0) begin
               $error("result transfer with no step pending: tdata %0h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_steps.pop_front();
               check_field("event_res", want.event_code, got.event_code);
               check_field("cell_row", want.row, got.row);
               check_field("cell_col", want.col, got.col);
               check_field("carved_dir", want.carved, got.carved);
               check_field("cells_visited", want.visited, got.visited);
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      corner_reg = mbt_pkg::CORNER_TOP_LEFT;
      restart_walk();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_border_and_carve();
      test_corner_restarts();
      test_random_walks();
      drain_results();
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
